@@ design/rv32_machine_trap_csr_unit_macros.svh @@
// ----------------------------------------------------------------------------
// rv32_machine_trap_csr_unit assertion macros
// Shorthand for the concurrent checks on the trap and CSR unit ports.
// ----------------------------------------------------------------------------
`ifndef RV32_MACHINE_TRAP_CSR_UNIT_MACROS_SVH
`define RV32_MACHINE_TRAP_CSR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define RV32MT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define RV32MT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/rv32mt_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32mt_pkg
// Types, encodings and CSR map shared by the machine trap and CSR unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32mt_pkg;

   // Opcodes handled by the unit
   localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
   localparam logic [6:0] OPC_SYSTEM   = 7'h73;
   localparam logic [6:0] OPC_AMO      = 7'h2F;

   // Encoding masks: bits outside the mask must be zero
   localparam logic [31:0] FENCE_MASK_A = 32'h0000107F;
   localparam logic [31:0] FENCE_MASK_B = 32'h0FF0007F;
   localparam logic [31:0] SYS_ENV_MASK = 32'h0010007F;
   localparam logic [31:0] SYS_RET_MASK = 32'hFFF0007F;
   localparam logic [31:0] INSTR_ECALL  = 32'h00000073;

   // Return-form funct12 codes
   localparam logic [11:0] F12_URET = 12'h002;
   localparam logic [11:0] F12_MRET = 12'h302;
   localparam logic [11:0] F12_WFI  = 12'h105;

   // SYSTEM funct3 with no CSR meaning
   localparam logic [2:0] F3_PRIV = 3'd4;

   // CSR funct3 low bits
   localparam logic [1:0] CSR_OP_RW = 2'd1;
   localparam logic [1:0] CSR_OP_RS = 2'd2;
   localparam logic [1:0] CSR_OP_RC = 2'd3;

   // AMO funct5 codes
   localparam logic [4:0] AMO_ADD  = 5'h00;
   localparam logic [4:0] AMO_SWAP = 5'h01;
   localparam logic [4:0] AMO_LR   = 5'h02;
   localparam logic [4:0] AMO_SC   = 5'h03;
   localparam logic [4:0] AMO_XOR  = 5'h04;
   localparam logic [4:0] AMO_OR   = 5'h08;
   localparam logic [4:0] AMO_AND  = 5'h0C;

   // Trap causes
   localparam logic [31:0] CAUSE_ILLEGAL = 32'd2;
   localparam logic [31:0] CAUSE_BUS     = 32'd5;
   localparam logic [31:0] CAUSE_ECALL_U = 32'd8;
   localparam logic [31:0] CAUSE_ECALL_M = 32'd11;
   localparam logic [31:0] CAUSE_TIMER   = 32'h80000007;

   // mstatus / mie bit positions
   localparam int MST_UIE  = 0;
   localparam int MST_MIE  = 3;
   localparam int MST_UPIE = 4;
   localparam int MST_MPIE = 7;
   localparam int MST_MPP_LO = 11;
   localparam int MST_MPP_HI = 12;
   localparam int MIE_MTIE = 7;

   // CSR addresses
   localparam logic [11:0] ADDR_MSTATUS   = 12'h300;
   localparam logic [11:0] ADDR_CYCLE     = 12'hC00;
   localparam logic [11:0] ADDR_MSCRATCH  = 12'h340;
   localparam logic [11:0] ADDR_MTVEC     = 12'h305;
   localparam logic [11:0] ADDR_MIE       = 12'h304;
   localparam logic [11:0] ADDR_MIP       = 12'h344;
   localparam logic [11:0] ADDR_MEPC      = 12'h341;
   localparam logic [11:0] ADDR_MTVAL     = 12'h343;
   localparam logic [11:0] ADDR_MCAUSE    = 12'h342;
   localparam logic [11:0] ADDR_MVENDORID = 12'hF11;
   localparam logic [11:0] ADDR_MISA      = 12'h301;

   // CSR RAM geometry and entry map
   localparam int CSR_RAM_DEPTH = 4;
   localparam int CSR_RAM_AW    = $clog2(CSR_RAM_DEPTH);

   typedef logic [CSR_RAM_AW-1:0] ram_idx_type;

   // RAM A entries
   localparam ram_idx_type RA_MCAUSE   = 2'd0;
   localparam ram_idx_type RA_CYCLE    = 2'd1;
   localparam ram_idx_type RA_MSCRATCH = 2'd2;
   localparam ram_idx_type RA_MIP      = 2'd3;
   // RAM B entries
   localparam ram_idx_type RB_MTVAL     = 2'd0;
   localparam ram_idx_type RB_MVENDORID = 2'd1;
   localparam ram_idx_type RB_MISA      = 2'd2;

   // Where a CSR lives
   typedef enum logic [2:0] {
      LOC_NONE,
      LOC_MSTATUS,
      LOC_MTVEC,
      LOC_MIE,
      LOC_MEPC,
      LOC_RAM_A,
      LOC_RAM_B
   } csr_loc_type;

   typedef struct packed {
      csr_loc_type loc;
      ram_idx_type idx;
   } csr_sel_type;

   // One accepted item
   typedef struct packed {
      logic        operation;
      logic [31:0] instr;
      logic [31:0] pc;
      logic [2:0]  cause;
      logic [31:0] rs1_value;
      logic [31:0] rs2_value;
      logic [31:0] mem_old;
   } req_type;

   // One result item
   typedef struct packed {
      logic [31:0] next_pc;
      logic        rd_write;
      logic [4:0]  rd_index;
      logic [31:0] rd_value;
      logic        mem_write;
      logic [31:0] mem_data;
      logic        status;
      logic        timer_clear;
      logic        timer_arm;
      logic        unknown_irq;
   } rsp_type;

   // Current CSR contents seen by the execute logic
   typedef struct packed {
      logic [31:0] mstatus;
      logic [31:0] mtvec;
      logic [31:0] mie;
      logic [31:0] mepc;
      logic [31:0] ram_a;
      logic [31:0] ram_b;
   } csr_view_type;

   // CSR updates produced by one item
   typedef struct packed {
      logic [31:0] mstatus;
      logic [31:0] mtvec;
      logic [31:0] mie;
      logic [31:0] mepc;
      logic        a_wr_en;
      ram_idx_type a_wr_idx;
      logic [31:0] a_wr_data;
      logic        b_wr_en;
      ram_idx_type b_wr_idx;
      logic [31:0] b_wr_data;
   } csr_upd_type;

   // Map a CSR address onto its home
   function automatic csr_sel_type csr_decode(input logic [11:0] addr);
      csr_sel_type sel;
      sel.loc = LOC_NONE;
      sel.idx = '0;
      case (addr)
         ADDR_MSTATUS:   sel.loc = LOC_MSTATUS;
         ADDR_MTVEC:     sel.loc = LOC_MTVEC;
         ADDR_MIE:       sel.loc = LOC_MIE;
         ADDR_MEPC:      sel.loc = LOC_MEPC;
         ADDR_MCAUSE:    begin sel.loc = LOC_RAM_A; sel.idx = RA_MCAUSE;    end
         ADDR_CYCLE:     begin sel.loc = LOC_RAM_A; sel.idx = RA_CYCLE;     end
         ADDR_MSCRATCH:  begin sel.loc = LOC_RAM_A; sel.idx = RA_MSCRATCH;  end
         ADDR_MIP:       begin sel.loc = LOC_RAM_A; sel.idx = RA_MIP;       end
         ADDR_MTVAL:     begin sel.loc = LOC_RAM_B; sel.idx = RB_MTVAL;     end
         ADDR_MVENDORID: begin sel.loc = LOC_RAM_B; sel.idx = RB_MVENDORID; end
         ADDR_MISA:      begin sel.loc = LOC_RAM_B; sel.idx = RB_MISA;      end
         default:        sel.loc = LOC_NONE;
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

@@ design/rv32mt_csr_ram.sv @@
// ----------------------------------------------------------------------------
// rv32mt_csr_ram
// Small CSR memory: one write and one registered read per cycle, valid bits
// so that never-written entries read zero, and same-edge write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32mt_csr_ram (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire rv32mt_pkg::ram_idx_type  rd_idx,
   input  wire logic                     wr_en,
   input  wire rv32mt_pkg::ram_idx_type  wr_idx,
   input  wire logic [31:0]              wr_data,
   output logic [31:0]                   rd_data
);
   import rv32mt_pkg::*;

   logic [31:0]              mem_ff [CSR_RAM_DEPTH];
   logic [CSR_RAM_DEPTH-1:0] valid_ff;
   logic [CSR_RAM_DEPTH-1:0] valid_in;
   logic [31:0]              rd_data_ff;
   logic                     rd_valid_ff;
   logic                     fwd_hit_ff;
   logic [31:0]              fwd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   // Mark written entries
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   // Read port, capturing a write to the same entry on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
            fwd_hit_ff  <= wr_en && (wr_idx == rd_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_idx];
         fwd_data_ff <= wr_data;
      end
   end

   // Forwarded data wins, unwritten entries read zero
   assign rd_data = fwd_hit_ff  ? fwd_data_ff :
                    rd_valid_ff ? rd_data_ff  : '0;

endmodule

`default_nettype wire

@@ design/rv32mt_exec.sv @@
// ----------------------------------------------------------------------------
// rv32mt_exec
// Execute logic: decodes one item, forms the result and the CSR updates
// (trap entry, xRET, CSR read-modify-write, AMO, interrupt causes).
// ----------------------------------------------------------------------------
`default_nettype none

module rv32mt_exec (
   input  wire rv32mt_pkg::req_type      req,
   input  wire rv32mt_pkg::csr_sel_type  sel,
   input  wire rv32mt_pkg::csr_view_type view,
   output rv32mt_pkg::rsp_type           rsp,
   output rv32mt_pkg::csr_upd_type       upd
);
   import rv32mt_pkg::*;

   // mstatus after trap entry: MPIE takes MIE, MIE clears
   function automatic logic [31:0] trap_mstatus(input logic [31:0] m, input logic clr_mpp);
      logic [31:0] r;
      r = m;
      r[MST_MPIE] = m[MST_MIE];
      r[MST_MIE]  = 1'b0;
      if (clr_mpp) begin
         r[MST_MPP_HI:MST_MPP_LO] = 2'b00;
      end
      return r;
   endfunction

   always_comb begin
      logic [31:0] npc;
      logic [31:0] mst;
      logic [31:0] src;
      logic [31:0] old;
      logic [31:0] nv;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [4:0]  f5;
      logic        ok;

      rd  = req.instr[11:7];
      f3  = req.instr[14:12];
      f5  = req.instr[31:27];
      npc = req.pc;
      mst = view.mstatus;
      src = f3[2] ? {27'd0, req.instr[19:15]} : req.rs1_value;
      ok  = 1'b1;

      rsp = '0;
      upd.mstatus   = view.mstatus;
      upd.mtvec     = view.mtvec;
      upd.mie       = view.mie;
      upd.mepc      = view.mepc;
      upd.a_wr_en   = 1'b0;
      upd.a_wr_idx  = sel.idx;
      upd.a_wr_data = '0;
      upd.b_wr_en   = 1'b0;
      upd.b_wr_idx  = sel.idx;
      upd.b_wr_data = '0;

      // Old value of the addressed CSR
      case (sel.loc)
         LOC_MSTATUS: old = view.mstatus;
         LOC_MTVEC:   old = view.mtvec;
         LOC_MIE:     old = view.mie;
         LOC_MEPC:    old = view.mepc;
         LOC_RAM_A:   old = view.ram_a;
         LOC_RAM_B:   old = view.ram_b;
         default:     old = '0;
      endcase

      case (f3[1:0])
         CSR_OP_RW: nv = src;
         CSR_OP_RS: nv = old | src;
         CSR_OP_RC: nv = old & ~src;
         default:   nv = old;
      endcase

      if (req.operation) begin
         // Interrupt causes, handled bus error then timer then unknown; timer overrides bus error
         if (req.cause[0]) begin
            upd.mepc      = npc - 32'd4;
            upd.a_wr_en   = 1'b1;
            upd.a_wr_idx  = RA_MCAUSE;
            upd.a_wr_data = CAUSE_BUS;
            upd.b_wr_en   = 1'b1;
            upd.b_wr_idx  = RB_MTVAL;
            upd.b_wr_data = '0;
            mst           = trap_mstatus(mst, 1'b0);
            npc           = view.mtvec;
         end
         if (req.cause[1]) begin
            rsp.timer_clear = 1'b1;
            upd.mepc      = npc - 32'd4;
            upd.a_wr_en   = 1'b1;
            upd.a_wr_idx  = RA_MCAUSE;
            upd.a_wr_data = CAUSE_TIMER;
            upd.b_wr_en   = 1'b1;
            upd.b_wr_idx  = RB_MTVAL;
            upd.b_wr_data = '0;
            mst           = trap_mstatus(mst, 1'b0);
            npc           = view.mtvec;
         end
         if (req.cause[2]) begin
            rsp.unknown_irq = 1'b1;
            npc = npc - 32'd4;
         end
         upd.mstatus = mst;
      end else begin
         case (req.instr[6:0])
            OPC_MISC_MEM: begin
               // Check the FENCE encodings only
               rsp.status = ((req.instr & ~FENCE_MASK_A) != '0) &&
                            ((req.instr & ~FENCE_MASK_B) != '0);
            end
            OPC_SYSTEM: begin
               if ((req.instr & ~SYS_ENV_MASK) == '0) begin
                  // ECALL traps, EBREAK does nothing
                  if (req.instr == INSTR_ECALL) begin
                     upd.mepc      = req.pc - 32'd4;
                     upd.a_wr_en   = 1'b1;
                     upd.a_wr_idx  = RA_MCAUSE;
                     upd.a_wr_data = (view.mstatus[MST_MPP_HI:MST_MPP_LO] != 2'b00) ?
                                     CAUSE_ECALL_M : CAUSE_ECALL_U;
                     upd.b_wr_en   = 1'b1;
                     upd.b_wr_idx  = RB_MTVAL;
                     upd.b_wr_data = '0;
                     upd.mstatus   = trap_mstatus(view.mstatus, 1'b0);
                     npc           = view.mtvec;
                  end
               end else if ((req.instr & ~SYS_RET_MASK) == '0) begin
                  case (req.instr[31:20])
                     F12_URET: begin
                        mst[MST_UIE]  = view.mstatus[MST_UPIE];
                        mst[MST_UPIE] = 1'b1;
                        mst[MST_MPP_HI:MST_MPP_LO] = 2'b00;
                        upd.mstatus = mst;
                        npc = view.mepc;
                     end
                     F12_MRET: begin
                        mst[MST_MIE]  = view.mstatus[MST_MPIE];
                        mst[MST_MPIE] = 1'b1;
                        mst[MST_MPP_HI:MST_MPP_LO] = 2'b00;
                        upd.mstatus = mst;
                        npc = view.mepc;
                     end
                     F12_WFI: begin
                        rsp.status = 1'b0;
                     end
                     default: begin
                        rsp.status = 1'b1;
                     end
                  endcase
               end else if (f3 != F3_PRIV) begin
                  // CSR read-modify-write, old value to rd
                  if (rd != 5'd0) begin
                     rsp.rd_write = 1'b1;
                     rsp.rd_index = rd;
                     rsp.rd_value = old;
                  end
                  case (sel.loc)
                     LOC_MSTATUS: upd.mstatus = nv;
                     LOC_MTVEC:   upd.mtvec   = nv;
                     LOC_MIE:     upd.mie     = nv;
                     LOC_MEPC:    upd.mepc    = nv;
                     LOC_RAM_A: begin
                        upd.a_wr_en   = 1'b1;
                        upd.a_wr_data = nv;
                     end
                     LOC_RAM_B: begin
                        upd.b_wr_en   = 1'b1;
                        upd.b_wr_data = nv;
                     end
                     default: begin
                        upd.a_wr_en = 1'b0;
                     end
                  endcase
               end else begin
                  rsp.status = 1'b1;
               end
            end
            OPC_AMO: begin
               rsp.rd_value  = req.mem_old;
               rsp.mem_write = 1'b1;
               case (f5)
                  AMO_LR:   rsp.mem_write = 1'b0;
                  AMO_SC: begin
                     rsp.rd_value = '0;
                     rsp.mem_data = req.rs2_value;
                  end
                  AMO_SWAP: rsp.mem_data = req.rs2_value;
                  AMO_ADD:  rsp.mem_data = req.mem_old + req.rs2_value;
                  AMO_XOR:  rsp.mem_data = req.mem_old ^ req.rs2_value;
                  AMO_AND:  rsp.mem_data = req.mem_old & req.rs2_value;
                  AMO_OR:   rsp.mem_data = req.mem_old | req.rs2_value;
                  default: begin
                     ok = 1'b0;
                     rsp.mem_write = 1'b0;
                  end
               endcase
               if (!ok) begin
                  rsp.status   = 1'b1;
                  rsp.rd_value = '0;
               end else if (rd != 5'd0) begin
                  rsp.rd_write = 1'b1;
                  rsp.rd_index = rd;
               end else begin
                  rsp.rd_value = '0;
               end
            end
            default: begin
               // Illegal opcode trap
               upd.mepc      = req.pc - 32'd4;
               upd.a_wr_en   = 1'b1;
               upd.a_wr_idx  = RA_MCAUSE;
               upd.a_wr_data = CAUSE_ILLEGAL;
               upd.b_wr_en   = 1'b1;
               upd.b_wr_idx  = RB_MTVAL;
               upd.b_wr_data = req.pc - 32'd4;
               upd.mstatus   = trap_mstatus(view.mstatus, 1'b1);
               npc           = view.mtvec;
            end
         endcase
         // Timer arm follows the updated enables
         rsp.timer_arm = upd.mstatus[MST_MIE] && upd.mie[MIE_MTIE];
      end

      rsp.next_pc = npc;
   end

endmodule

`default_nettype wire

@@ design/rv32_machine_trap_csr_unit.sv @@
// ----------------------------------------------------------------------------
// rv32_machine_trap_csr_unit
// Machine-mode trap and CSR unit for a small RV32 core.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries either an instruction the core could not execute
//   (req_operation = 0) or a set of pending interrupt causes (= 1), with pc,
//   rs1/rs2 contents and the old memory word for AMOs. Each transfer produces
//   exactly one rsp_ transfer with the resume pc, any rd write, any AMO store,
//   status and the timer handshake flags.
//   Timing: the transfer edge reads the CSR memories and loads the execute
//   stage, which modifies, writes back and loads the result register as it
//   advances. Throughput: one item per cycle while rsp_ready is high, set
//   by the single read/write port of each CSR memory; a same-entry write
//   and read on one edge is forwarded.
//   Reset clears every CSR to zero at once (valid bits on the memories) and
//   empties the pipeline; no clearing pass is needed.
//   When rsp_ready is low the result is held in the output register, the item
//   behind it waits in the execute stage and req_ready drops once both are
//   full.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_machine_trap_csr_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [31:0] req_instr,
   input  wire logic [31:0] req_pc,
   input  wire logic [2:0]  req_cause,
   input  wire logic [31:0] req_rs1_value,
   input  wire logic [31:0] req_rs2_value,
   input  wire logic [31:0] req_mem_old,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_rd_write,
   output logic [4:0]       rsp_rd_index,
   output logic [31:0]      rsp_rd_value,
   output logic             rsp_mem_write,
   output logic [31:0]      rsp_mem_data,
   output logic             rsp_status,
   output logic             rsp_timer_clear,
   output logic             rsp_timer_arm,
   output logic             rsp_unknown_irq
);
   import rv32mt_pkg::*;

   req_type      req_in;
   csr_sel_type  sel_in;
   logic         req_accept;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_type      s1_req_ff;
   csr_sel_type  s1_sel_ff;
   logic         s1_advance;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_type      rsp_data_ff;
   rsp_type      rsp_data_in;

   logic [31:0]  mstatus_ff;
   logic [31:0]  mtvec_ff;
   logic [31:0]  mie_ff;
   logic [31:0]  mepc_ff;

   logic [31:0]  ram_a_rd;
   logic [31:0]  ram_b_rd;
   csr_view_type view;
   csr_upd_type  upd;

   // Gather the request and find the addressed CSR
   assign req_in = '{operation: req_operation, instr: req_instr, pc: req_pc,
                     cause: req_cause, rs1_value: req_rs1_value,
                     rs2_value: req_rs2_value, mem_old: req_mem_old};
   assign sel_in = csr_decode(req_instr[31:20]);

   // Pipeline flow control
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign req_accept   = req_valid && req_ready;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   // CSR memories, read on transfer, written when the item leaves execute
   rv32mt_csr_ram u_ram_a (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_idx  (sel_in.idx),
      .wr_en   (s1_advance && upd.a_wr_en),
      .wr_idx  (upd.a_wr_idx),
      .wr_data (upd.a_wr_data),
      .rd_data (ram_a_rd)
   );

   rv32mt_csr_ram u_ram_b (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_idx  (sel_in.idx),
      .wr_en   (s1_advance && upd.b_wr_en),
      .wr_idx  (upd.b_wr_idx),
      .wr_data (upd.b_wr_data),
      .rd_data (ram_b_rd)
   );

   // Execute stage
   assign view = '{mstatus: mstatus_ff, mtvec: mtvec_ff, mie: mie_ff,
                   mepc: mepc_ff, ram_a: ram_a_rd, ram_b: ram_b_rd};

   rv32mt_exec u_exec (
      .req  (s1_req_ff),
      .sel  (s1_sel_ff),
      .view (view),
      .rsp  (rsp_data_in),
      .upd  (upd)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Frequently used CSRs held in flops, updated as the item retires
   always_ff @(posedge clock) begin
      if (reset) begin
         mstatus_ff <= '0;
         mtvec_ff   <= '0;
         mie_ff     <= '0;
         mepc_ff    <= '0;
      end else if (s1_advance) begin
         mstatus_ff <= upd.mstatus;
         mtvec_ff   <= upd.mtvec;
         mie_ff     <= upd.mie;
         mepc_ff    <= upd.mepc;
      end
   end

   // Payload: advance the item into execute, hold the result while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_in;
         s1_sel_ff <= sel_in;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_data_ff.next_pc;
   assign rsp_rd_write    = rsp_data_ff.rd_write;
   assign rsp_rd_index    = rsp_data_ff.rd_index;
   assign rsp_rd_value    = rsp_data_ff.rd_value;
   assign rsp_mem_write   = rsp_data_ff.mem_write;
   assign rsp_mem_data    = rsp_data_ff.mem_data;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_timer_clear = rsp_data_ff.timer_clear;
   assign rsp_timer_arm   = rsp_data_ff.timer_arm;
   assign rsp_unknown_irq = rsp_data_ff.unknown_irq;

endmodule

`default_nettype wire

@@ design/rv32mt_checker.sv @@
// ----------------------------------------------------------------------------
// rv32mt_checker
// Port-level checks on the trap and CSR unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv32_machine_trap_csr_unit_macros.svh"

module rv32mt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_next_pc,
   input wire logic        rsp_rd_write,
   input wire logic [4:0]  rsp_rd_index,
   input wire logic [31:0] rsp_rd_value,
   input wire logic        rsp_mem_write,
   input wire logic [31:0] rsp_mem_data,
   input wire logic        rsp_status,
   input wire logic        rsp_timer_clear,
   input wire logic        rsp_timer_arm,
   input wire logic        rsp_unknown_irq
);

   // No register write means no index and no value
   `RV32MT_ASSERT_IMPLY(a_rd_quiet, clock, reset, rsp_valid && !rsp_rd_write, (rsp_rd_index == 5'd0) && (rsp_rd_value == 32'd0), "rd fields set without rd_write")

   // No store means no store data
   `RV32MT_ASSERT_IMPLY(a_mem_quiet, clock, reset, rsp_valid && !rsp_mem_write, rsp_mem_data == 32'd0, "mem_data set without mem_write")

   // Interrupt results carry no instruction side effects
   `RV32MT_ASSERT_IMPLY(a_irq_clean, clock, reset, rsp_valid && (rsp_timer_clear || rsp_unknown_irq), !rsp_timer_arm && !rsp_rd_write && !rsp_mem_write && !rsp_status, "interrupt result with instruction effects")

   // Reset empties the result register
   `RV32MT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // A stalled result holds
   `RV32MT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_pc) && $stable(rsp_rd_value), "stalled result changed")

endmodule

bind rv32_machine_trap_csr_unit rv32mt_checker u_rv32mt_checker (.*);

`default_nettype wire
